// ===== sv/epoch_seconds_to_calendar_defines.svh =====
// Assertion helpers shared by the calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define E2C_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define E2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/e2c_pkg.sv =====
package e2c_pkg;

   typedef struct packed {
      logic [7:0] year_since_1900;
      logic [3:0] month;
      logic [4:0] day_of_month;
      logic [2:0] weekday;
   } date_type;

endpackage

// ===== sv/e2c_date.sv =====
module e2c_date import e2c_pkg::*; (
   input  logic        clock,
   input  logic        advance,
   input  logic [15:0] days,
   output date_type    date
);

   localparam logic [18:0] RECIP_1461 = 19'((64'd1 << 29) / 1461);
   localparam logic [16:0] RECIP_7    = 17'((64'd1 << 19) / 7);
   localparam logic [11:0] RECIP_367  = 12'((64'd1 << 20) / 367);

   // First day (zero based) of each month on the 367/12 grid
   function automatic logic [8:0] month_start(input logic [3:0] mon);
      logic [8:0] start;
      case (mon)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd183;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd336;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

   // stage 4: quotient estimates for the four-year cycle and the week
   logic [17:0] cyc_num;
   logic [36:0] cyc_prod;
   logic [16:0] wk_num;
   logic [33:0] wk_prod;
   logic [15:0] days4_ff;
   logic [7:0]  yest4_ff;
   logic [12:0] west4_ff;

   assign cyc_num  = {days, 2'b10};
   assign cyc_prod = 37'(cyc_num) * 37'(RECIP_1461);
   assign wk_num   = 17'(days) + 17'd4;
   assign wk_prod  = 34'(wk_num) * 34'(RECIP_7);

   always_ff @(posedge clock) begin
      if (advance) begin
         days4_ff <= days;
         yest4_ff <= cyc_prod[36:29];
         west4_ff <= wk_prod[31:19];
      end
   end

   // stage 5: remainder corrections
   logic [17:0] cyc_num4;
   logic [17:0] cyc_rem;
   logic [16:0] wk_num4;
   logic [16:0] wk_rem;
   logic [15:0] days5_ff;
   logic [7:0]  yrs5_ff;
   logic [2:0]  wday5_ff;

   assign cyc_num4 = {days4_ff, 2'b10};
   assign cyc_rem  = 18'(cyc_num4 - 18'(yest4_ff) * 18'(1461));
   assign wk_num4  = 17'(days4_ff) + 17'd4;
   assign wk_rem   = 17'(wk_num4 - 17'(west4_ff) * 17'(7));

   always_ff @(posedge clock) begin
      if (advance) begin
         days5_ff <= days4_ff;
         yrs5_ff  <= yest4_ff + 8'(cyc_rem >= 18'd1461);
         wday5_ff <= (wk_rem >= 17'd7) ? 3'(wk_rem - 17'd7) : 3'(wk_rem);
      end
   end

   // stage 6: day of year, shifted so March on follows the 367/12 grid
   logic [7:0]  year6;
   logic        leap6;
   logic [17:0] cyc_base;
   logic [8:0]  yday6;
   logic [8:0]  adj6;
   logic [7:0]  year6_ff;
   logic [8:0]  adj6_ff;
   logic [2:0]  wday6_ff;

   assign year6    = yrs5_ff + 8'd70;
   assign leap6    = (year6[1:0] == 2'b00);
   assign cyc_base = 18'(yrs5_ff) * 18'(1461) + 18'd1;
   assign yday6    = 9'(days5_ff - cyc_base[17:2]);

   always_comb begin
      adj6 = yday6;
      if (yday6 > 9'd58 + 9'(leap6)) begin
         adj6 = yday6 + (leap6 ? 9'd1 : 9'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         year6_ff <= year6;
         adj6_ff  <= adj6;
         wday6_ff <= wday5_ff;
      end
   end

   // stage 7: month estimate
   logic [12:0] mon_num;
   logic [24:0] mon_prod;
   logic [12:0] num7_ff;
   logic [3:0]  mest7_ff;
   logic [8:0]  adj7_ff;
   logic [7:0]  year7_ff;
   logic [2:0]  wday7_ff;

   assign mon_num  = 13'(adj6_ff) * 13'(12) + 13'd6;
   assign mon_prod = 25'(mon_num) * 25'(RECIP_367);

   always_ff @(posedge clock) begin
      if (advance) begin
         num7_ff  <= mon_num;
         mest7_ff <= mon_prod[23:20];
         adj7_ff  <= adj6_ff;
         year7_ff <= year6_ff;
         wday7_ff <= wday6_ff;
      end
   end

   // stage 8: month correction
   logic [12:0] mon_rem;
   logic [3:0]  mon8_ff;
   logic [8:0]  adj8_ff;
   logic [7:0]  year8_ff;
   logic [2:0]  wday8_ff;

   assign mon_rem = 13'(num7_ff - 13'(mest7_ff) * 13'(367));

   always_ff @(posedge clock) begin
      if (advance) begin
         mon8_ff  <= mest7_ff + 4'(mon_rem >= 13'd367);
         adj8_ff  <= adj7_ff;
         year8_ff <= year7_ff;
         wday8_ff <= wday7_ff;
      end
   end

   // stage 9: day of month
   logic [8:0] mday9;
   date_type   date_ff;

   assign mday9 = 9'(adj8_ff + 9'd1 - month_start(mon8_ff));

   always_ff @(posedge clock) begin
      if (advance) begin
         date_ff.year_since_1900 <= year8_ff;
         date_ff.month           <= mon8_ff;
         date_ff.day_of_month    <= mday9[4:0];
         date_ff.weekday         <= wday8_ff;
      end
   end

   assign date = date_ff;

endmodule

// ===== sv/epoch_seconds_to_calendar.sv =====
// Epoch seconds to calendar time converter.
// One item per cycle while not stalled; the output stage stalls the whole pipe
// as one. Each constant division is a reciprocal multiply plus a one-step
// correction, one register stage each; the day division adds a remainder stage.
// Reset (synchronous, active high) clears the stage valid bits only.
`include "epoch_seconds_to_calendar_defines.svh"

module epoch_seconds_to_calendar import e2c_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // epoch_seconds[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // second, minute, hour, weekday, day_of_month,
                                    // month, year_since_1900, zero fill
);

   localparam int STAGES = 9;

   localparam logic [31:0] RECIP_675   = 32'((64'd1 << 41) / 675);
   localparam logic [17:0] RECIP_60SOD = 18'((64'd1 << 23) / 60);
   localparam logic [11:0] RECIP_60MIN = 12'((64'd1 << 17) / 60);

   logic              advance;
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   assign advance  = !valid_ff[STAGES-1] || rsp_tready;
   assign valid_in = {valid_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[STAGES-1];

   // stage 1: seconds / 86400 = (seconds >> 7) / 675, estimate
   logic [31:0] t1_ff;
   logic [56:0] p1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff <= req_tdata;
         p1_ff <= 57'(req_tdata[31:7]) * 57'(RECIP_675);
      end
   end

   // stage 2: remainder of the estimate
   logic [15:0] q1;
   logic [24:0] day_rem_wide;
   logic [15:0] q2_ff;
   logic [10:0] r2_ff;
   logic [6:0]  tlo2_ff;

   assign q1           = p1_ff[56:41];
   assign day_rem_wide = 25'(t1_ff[31:7] - 25'(q1) * 25'(675));

   always_ff @(posedge clock) begin
      if (advance) begin
         q2_ff   <= q1;
         r2_ff   <= day_rem_wide[10:0];
         tlo2_ff <= t1_ff[6:0];
      end
   end

   // stage 3: whole days and second of day
   logic        day_fix;
   logic [10:0] day_rem;
   logic [15:0] days3_ff;
   logic [16:0] sod3_ff;

   assign day_fix = (r2_ff >= 11'd675);
   assign day_rem = day_fix ? (r2_ff - 11'd675) : r2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         days3_ff <= q2_ff + 16'(day_fix);
         sod3_ff  <= {day_rem[9:0], tlo2_ff};
      end
   end

   // stage 4: minutes of day, estimate
   logic [34:0] sod_prod;
   logic [16:0] sod4_ff;
   logic [10:0] mest4_ff;

   assign sod_prod = 35'(sod3_ff) * 35'(RECIP_60SOD);

   always_ff @(posedge clock) begin
      if (advance) begin
         sod4_ff  <= sod3_ff;
         mest4_ff <= sod_prod[33:23];
      end
   end

   // stage 5: minutes of day and second
   logic [16:0] sec_rem_wide;
   logic [6:0]  sec_rem;
   logic [10:0] mins5_ff;
   logic [5:0]  sec5_ff;

   assign sec_rem_wide = 17'(sod4_ff - 17'(mest4_ff) * 17'(60));
   assign sec_rem      = sec_rem_wide[6:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         mins5_ff <= mest4_ff + 11'(sec_rem >= 7'd60);
         sec5_ff  <= (sec_rem >= 7'd60) ? 6'(sec_rem - 7'd60) : sec_rem[5:0];
      end
   end

   // stage 6: hour estimate
   logic [22:0] min_prod;
   logic [10:0] mins6_ff;
   logic [4:0]  hest6_ff;
   logic [5:0]  sec6_ff;

   assign min_prod = 23'(mins5_ff) * 23'(RECIP_60MIN);

   always_ff @(posedge clock) begin
      if (advance) begin
         mins6_ff <= mins5_ff;
         hest6_ff <= min_prod[21:17];
         sec6_ff  <= sec5_ff;
      end
   end

   // stage 7: hour and minute
   logic [10:0] min_rem_wide;
   logic [6:0]  min_rem;
   logic [4:0]  hour7_ff;
   logic [5:0]  minute7_ff;
   logic [5:0]  sec7_ff;

   assign min_rem_wide = 11'(mins6_ff - 11'(hest6_ff) * 11'(60));
   assign min_rem      = min_rem_wide[6:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         hour7_ff   <= hest6_ff + 5'(min_rem >= 7'd60);
         minute7_ff <= (min_rem >= 7'd60) ? 6'(min_rem - 7'd60) : min_rem[5:0];
         sec7_ff    <= sec6_ff;
      end
   end

   // stages 8 and 9: hold time of day while the date path finishes
   logic [4:0] hour8_ff;
   logic [5:0] minute8_ff;
   logic [5:0] sec8_ff;
   logic [4:0] hour9_ff;
   logic [5:0] minute9_ff;
   logic [5:0] sec9_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         hour8_ff   <= hour7_ff;
         minute8_ff <= minute7_ff;
         sec8_ff    <= sec7_ff;
         hour9_ff   <= hour8_ff;
         minute9_ff <= minute8_ff;
         sec9_ff    <= sec8_ff;
      end
   end

   date_type date;

   e2c_date u_date (
      .clock   (clock),
      .advance (advance),
      .days    (days3_ff),
      .date    (date)
   );

   assign rsp_tdata = {3'b000, date.year_since_1900, date.month, date.day_of_month,
                       date.weekday, hour9_ff, minute9_ff, sec9_ff};

   `E2C_ASSERT_IMPL(a_time_range, clock, reset, rsp_tvalid,
      (sec9_ff < 6'd60) && (minute9_ff < 6'd60) && (hour9_ff < 5'd24),
      "time of day out of range")

   `E2C_ASSERT_IMPL(a_date_range, clock, reset, rsp_tvalid,
      (date.weekday < 3'd7) && (date.day_of_month != 5'd0) && (date.month < 4'd12)
      && (date.year_since_1900 >= 8'd70) && (date.year_since_1900 <= 8'd206),
      "calendar date out of range")

   `E2C_ASSERT_NEXT(a_accept_captured, clock, reset, req_tvalid && req_tready,
      valid_ff[0], "accepted transfer not captured in first stage")

endmodule
